>>> sv/closest_hit_ray_triangle_defines.svh
// Assertion macros for the closest-hit ray/triangle engine.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef CLOSEST_HIT_RAY_TRIANGLE_DEFINES_SVH
`define CLOSEST_HIT_RAY_TRIANGLE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CHRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chrt assertion failed");
// next-cycle implication
`define CHRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chrt assertion failed");
`else
`define CHRT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CHRT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/chrt_pkg.sv
// Package for the closest-hit ray/triangle engine: widths, codes, command
// and status structs, and the multiply-accumulate microprogram. No dependencies.
package chrt_pkg;

   localparam int COORD_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int DIST_W     = 26;
   localparam int MESH_W     = 8;
   localparam int TRI_W      = 20;
   localparam int DET_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DIFF_W   = COORD_W + 1;     // edge and offset vectors
   localparam int WIDE_B_W = 2 * DIFF_W + 1;  // cross products
   localparam int LO_W     = 26;              // low half of a wide operand
   localparam int MUL_B_W  = LO_W + 1;
   localparam int PROD_W   = DIFF_W + MUL_B_W;
   localparam int ACC_W    = 80;
   localparam int REM_W    = ACC_W + DIST_W;
   localparam int PC_W     = 6;
   localparam int CNT_W    = 5;

   localparam logic [DET_W-1:0] MIN_DET_RESET = 32'd281474977;

   localparam logic [PC_W-1:0] PC_DOT_LAST  = PC_W'(35);
   localparam logic [PC_W-1:0] PC_HIT_FIRST = PC_W'(36);
   localparam logic [PC_W-1:0] PC_HIT_LAST  = PC_W'(38);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z, REG_MIN_DET
   } csr_reg_type;

   typedef enum logic [3:0] {
      A_D0, A_D1, A_D2, A_E1_0, A_E1_1, A_E1_2,
      A_E2_0, A_E2_1, A_E2_2, A_S0, A_S1, A_S2
   } asel_type;

   typedef enum logic [3:0] {
      B_E1_0, B_E1_1, B_E1_2, B_E2_0, B_E2_1, B_E2_2,
      B_P0, B_P1, B_P2, B_Q0, B_Q1, B_Q2, B_T
   } bsel_type;

   typedef enum logic [1:0] {PART_NARROW, PART_LO, PART_HI} part_type;

   typedef enum logic [1:0] {ACC_ADD, ACC_CLEAR, ACC_ORIGIN} accmode_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
      DST_DET, DST_UN, DST_VN, DST_TN, DST_HX, DST_HY, DST_HZ
   } dst_type;

   typedef struct packed {
      asel_type    asel;
      bsel_type    bsel;
      part_type    part;
      logic        neg;
      accmode_type mode;
      dst_type     dst;
   } uop_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_MAC_DRAIN, ST_ADJUST, ST_CHECK, ST_DIV_INIT,
      ST_DIV, ST_UPDATE, ST_HIT, ST_HIT_DRAIN, ST_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic    capture;
      logic    uop_valid;
      uop_type uop;
      logic    adjust;
      logic    check;
      logic    div_init;
      logic    div_step;
      logic    update;
      logic    load_out;
   } cmd_type;

   typedef struct packed {
      logic last;
   } stat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_a_x;
      logic signed [COORD_W-1:0] vertex_a_y;
      logic signed [COORD_W-1:0] vertex_a_z;
      logic signed [COORD_W-1:0] vertex_b_x;
      logic signed [COORD_W-1:0] vertex_b_y;
      logic signed [COORD_W-1:0] vertex_b_z;
      logic signed [COORD_W-1:0] vertex_c_x;
      logic signed [COORD_W-1:0] vertex_c_y;
      logic signed [COORD_W-1:0] vertex_c_z;
      logic [MESH_W-1:0]         mesh_number;
      logic [TRI_W-1:0]          triangle_number;
      logic                      last_triangle;
   } tri_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] hit_x;
      logic signed [COORD_W-1:0] hit_y;
      logic signed [COORD_W-1:0] hit_z;
      logic [DIST_W-1:0]         hit_distance;
      logic [MESH_W-1:0]         hit_mesh;
      logic [TRI_W-1:0]          hit_triangle;
   } res_type;

   function automatic uop_type mk_uop(asel_type a, bsel_type b, part_type pt,
                                      logic ng, accmode_type m, dst_type d);
      uop_type u;
      u.asel = a;
      u.bsel = b;
      u.part = pt;
      u.neg  = ng;
      u.mode = m;
      u.dst  = d;
      return u;
   endfunction

   // Cross products first (p = dir x e2, q = s x e1), then the four dot
   // products in low/high halves, then the three hit-point coordinates.
   function automatic uop_type uop_rom(logic [PC_W-1:0] pc);
      uop_type u;
      u = mk_uop(A_D0, B_E1_0, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
      unique case (pc)
         PC_W'(0):  u = mk_uop(A_D1, B_E2_2, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(1):  u = mk_uop(A_D2, B_E2_1, PART_NARROW, 1'b1, ACC_ADD, DST_P0);
         PC_W'(2):  u = mk_uop(A_D2, B_E2_0, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(3):  u = mk_uop(A_D0, B_E2_2, PART_NARROW, 1'b1, ACC_ADD, DST_P1);
         PC_W'(4):  u = mk_uop(A_D0, B_E2_1, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(5):  u = mk_uop(A_D1, B_E2_0, PART_NARROW, 1'b1, ACC_ADD, DST_P2);
         PC_W'(6):  u = mk_uop(A_S1, B_E1_2, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(7):  u = mk_uop(A_S2, B_E1_1, PART_NARROW, 1'b1, ACC_ADD, DST_Q0);
         PC_W'(8):  u = mk_uop(A_S2, B_E1_0, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(9):  u = mk_uop(A_S0, B_E1_2, PART_NARROW, 1'b1, ACC_ADD, DST_Q1);
         PC_W'(10): u = mk_uop(A_S0, B_E1_1, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(11): u = mk_uop(A_S1, B_E1_0, PART_NARROW, 1'b1, ACC_ADD, DST_Q2);
         PC_W'(12): u = mk_uop(A_E1_0, B_P0, PART_LO, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(13): u = mk_uop(A_E1_0, B_P0, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(14): u = mk_uop(A_E1_1, B_P1, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(15): u = mk_uop(A_E1_1, B_P1, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(16): u = mk_uop(A_E1_2, B_P2, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(17): u = mk_uop(A_E1_2, B_P2, PART_HI, 1'b0, ACC_ADD, DST_DET);
         PC_W'(18): u = mk_uop(A_S0, B_P0, PART_LO, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(19): u = mk_uop(A_S0, B_P0, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(20): u = mk_uop(A_S1, B_P1, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(21): u = mk_uop(A_S1, B_P1, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(22): u = mk_uop(A_S2, B_P2, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(23): u = mk_uop(A_S2, B_P2, PART_HI, 1'b0, ACC_ADD, DST_UN);
         PC_W'(24): u = mk_uop(A_D0, B_Q0, PART_LO, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(25): u = mk_uop(A_D0, B_Q0, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(26): u = mk_uop(A_D1, B_Q1, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(27): u = mk_uop(A_D1, B_Q1, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(28): u = mk_uop(A_D2, B_Q2, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(29): u = mk_uop(A_D2, B_Q2, PART_HI, 1'b0, ACC_ADD, DST_VN);
         PC_W'(30): u = mk_uop(A_E2_0, B_Q0, PART_LO, 1'b0, ACC_CLEAR, DST_NONE);
         PC_W'(31): u = mk_uop(A_E2_0, B_Q0, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(32): u = mk_uop(A_E2_1, B_Q1, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(33): u = mk_uop(A_E2_1, B_Q1, PART_HI, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(34): u = mk_uop(A_E2_2, B_Q2, PART_LO, 1'b0, ACC_ADD, DST_NONE);
         PC_W'(35): u = mk_uop(A_E2_2, B_Q2, PART_HI, 1'b0, ACC_ADD, DST_TN);
         PC_W'(36): u = mk_uop(A_D0, B_T, PART_NARROW, 1'b0, ACC_ORIGIN, DST_HX);
         PC_W'(37): u = mk_uop(A_D1, B_T, PART_NARROW, 1'b0, ACC_ORIGIN, DST_HY);
         PC_W'(38): u = mk_uop(A_D2, B_T, PART_NARROW, 1'b0, ACC_ORIGIN, DST_HZ);
         default:   u = mk_uop(A_D0, B_E1_0, PART_NARROW, 1'b0, ACC_CLEAR, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

>>> sv/chrt_req_if.sv
// Triangle request channel: valid/ready plus one triangle and its identifiers.
// Depends on chrt_pkg for field widths.
interface chrt_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_a_x;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_a_y;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_a_z;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_b_x;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_b_y;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_b_z;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_c_x;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_c_y;
   logic signed [chrt_pkg::COORD_W-1:0] vertex_c_z;
   logic [chrt_pkg::MESH_W-1:0]         mesh_number;
   logic [chrt_pkg::TRI_W-1:0]          triangle_number;
   logic                               last_triangle;

   modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                   vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                   mesh_number, triangle_number, last_triangle, input ready);
   modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                 vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                 mesh_number, triangle_number, last_triangle, output ready);
endinterface

>>> sv/chrt_rsp_if.sv
// Result channel: valid/ready plus the closest hit of one ray query.
// Depends on chrt_pkg for field widths.
interface chrt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic signed [chrt_pkg::COORD_W-1:0] hit_x;
   logic signed [chrt_pkg::COORD_W-1:0] hit_y;
   logic signed [chrt_pkg::COORD_W-1:0] hit_z;
   logic [chrt_pkg::DIST_W-1:0]         hit_distance;
   logic [chrt_pkg::MESH_W-1:0]         hit_mesh;
   logic [chrt_pkg::TRI_W-1:0]          hit_triangle;

   modport source (output valid, hit, hit_x, hit_y, hit_z, hit_distance, hit_mesh,
                   hit_triangle, input ready);
   modport sink (input valid, hit, hit_x, hit_y, hit_z, hit_distance, hit_mesh,
                 hit_triangle, output ready);
endinterface

>>> sv/chrt_csr_if.sv
// Register write channel: valid/ready, register index and write data.
// Depends on chrt_pkg for widths.
interface chrt_csr_if;
   logic                              valid;
   logic                              ready;
   logic [chrt_pkg::CSR_IDX_W-1:0]    index;
   logic [chrt_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/chrt_datapath.sv
// Datapath: ray registers, shared 25x27 multiplier with 80-bit accumulator,
// sign/range checks, bit-serial divider and the closest-hit keeper. Uses chrt_pkg.
module chrt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  chrt_pkg::cmd_type             cmd,
   output chrt_pkg::stat_type            stat,
   input  chrt_pkg::tri_type             tri_in,
   input  logic                          csr_we,
   input  logic [chrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chrt_pkg::CSR_DATA_W-1:0] csr_data,
   output chrt_pkg::res_type             res
);

   localparam logic signed [chrt_pkg::ACC_W-1:0] COORD_MAX =
      chrt_pkg::ACC_W'((64'sd1 <<< (chrt_pkg::COORD_W - 1)) - 64'sd1);
   localparam logic signed [chrt_pkg::ACC_W-1:0] COORD_MIN =
      -chrt_pkg::ACC_W'(64'sd1 <<< (chrt_pkg::COORD_W - 1));

   // ray registers
   logic signed [chrt_pkg::COORD_W-1:0] org_ff [3];
   logic signed [chrt_pkg::COORD_W-1:0] dir_ff [3];
   logic [chrt_pkg::DET_W-1:0]          min_det_ff;

   // triangle operands
   logic signed [chrt_pkg::DIFF_W-1:0]   e1_ff [3];
   logic signed [chrt_pkg::DIFF_W-1:0]   e2_ff [3];
   logic signed [chrt_pkg::DIFF_W-1:0]   s_ff [3];
   logic signed [chrt_pkg::WIDE_B_W-1:0] p_ff [3];
   logic signed [chrt_pkg::WIDE_B_W-1:0] q_ff [3];
   logic signed [chrt_pkg::ACC_W-1:0]    det_ff, un_ff, vn_ff, tn_ff, acc_ff;
   logic [chrt_pkg::MESH_W-1:0]          mesh_ff;
   logic [chrt_pkg::TRI_W-1:0]           tri_ff;
   logic                                 last_ff;

   // multiplier stage
   logic signed [chrt_pkg::PROD_W-1:0]   prod_ff;
   chrt_pkg::uop_type                    uop_ff;
   logic                                 uop_v_ff;

   // divider and keeper
   logic [chrt_pkg::REM_W-1:0]  rem_ff, dsh_ff;
   logic [chrt_pkg::DIST_W-1:0] t_ff, best_ff;
   logic                        sat_ff, ok_ff, found_ff;
   logic [chrt_pkg::MESH_W-1:0] best_mesh_ff;
   logic [chrt_pkg::TRI_W-1:0]  best_tri_ff;
   logic signed [chrt_pkg::COORD_W-1:0] hpt_ff [3];
   chrt_pkg::res_type           res_ff;

   logic signed [chrt_pkg::DIFF_W-1:0]   op_a;
   logic signed [chrt_pkg::WIDE_B_W-1:0] op_b;
   logic signed [chrt_pkg::MUL_B_W-1:0]  b_part;
   logic signed [chrt_pkg::ACC_W-1:0]    term, base, acc_in, flo, abs_det, sum_uv;
   logic signed [chrt_pkg::COORD_W-1:0]  coord_sat;
   logic                                 degen, bad, div_ge;
   logic [chrt_pkg::DIST_W-1:0]          t_q;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0]  <= '0;
         org_ff[1]  <= '0;
         org_ff[2]  <= '0;
         dir_ff[0]  <= '0;
         dir_ff[1]  <= '0;
         dir_ff[2]  <= '0;
         min_det_ff <= chrt_pkg::MIN_DET_RESET;
      end else if (csr_we) begin
         unique case (chrt_pkg::csr_reg_type'(csr_index))
            chrt_pkg::REG_ORIGIN_X: org_ff[0] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_ORIGIN_Y: org_ff[1] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_ORIGIN_Z: org_ff[2] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_DIR_X:    dir_ff[0] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_DIR_Y:    dir_ff[1] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_DIR_Z:    dir_ff[2] <= csr_data[chrt_pkg::COORD_W-1:0];
            chrt_pkg::REG_MIN_DET:  min_det_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // operand selection
   always_comb begin
      case (cmd.uop.asel)
         chrt_pkg::A_D0:   op_a = chrt_pkg::DIFF_W'(dir_ff[0]);
         chrt_pkg::A_D1:   op_a = chrt_pkg::DIFF_W'(dir_ff[1]);
         chrt_pkg::A_D2:   op_a = chrt_pkg::DIFF_W'(dir_ff[2]);
         chrt_pkg::A_E1_0: op_a = e1_ff[0];
         chrt_pkg::A_E1_1: op_a = e1_ff[1];
         chrt_pkg::A_E1_2: op_a = e1_ff[2];
         chrt_pkg::A_E2_0: op_a = e2_ff[0];
         chrt_pkg::A_E2_1: op_a = e2_ff[1];
         chrt_pkg::A_E2_2: op_a = e2_ff[2];
         chrt_pkg::A_S0:   op_a = s_ff[0];
         chrt_pkg::A_S1:   op_a = s_ff[1];
         chrt_pkg::A_S2:   op_a = s_ff[2];
         default:          op_a = '0;
      endcase
      case (cmd.uop.bsel)
         chrt_pkg::B_E1_0: op_b = chrt_pkg::WIDE_B_W'(e1_ff[0]);
         chrt_pkg::B_E1_1: op_b = chrt_pkg::WIDE_B_W'(e1_ff[1]);
         chrt_pkg::B_E1_2: op_b = chrt_pkg::WIDE_B_W'(e1_ff[2]);
         chrt_pkg::B_E2_0: op_b = chrt_pkg::WIDE_B_W'(e2_ff[0]);
         chrt_pkg::B_E2_1: op_b = chrt_pkg::WIDE_B_W'(e2_ff[1]);
         chrt_pkg::B_E2_2: op_b = chrt_pkg::WIDE_B_W'(e2_ff[2]);
         chrt_pkg::B_P0:   op_b = p_ff[0];
         chrt_pkg::B_P1:   op_b = p_ff[1];
         chrt_pkg::B_P2:   op_b = p_ff[2];
         chrt_pkg::B_Q0:   op_b = q_ff[0];
         chrt_pkg::B_Q1:   op_b = q_ff[1];
         chrt_pkg::B_Q2:   op_b = q_ff[2];
         chrt_pkg::B_T:    op_b = chrt_pkg::WIDE_B_W'(best_ff);
         default:          op_b = '0;
      endcase
      case (cmd.uop.part)
         chrt_pkg::PART_LO:
            b_part = chrt_pkg::MUL_B_W'({1'b0, op_b[chrt_pkg::LO_W-1:0]});
         chrt_pkg::PART_HI:
            b_part = chrt_pkg::MUL_B_W'($signed(op_b[chrt_pkg::WIDE_B_W-1:chrt_pkg::LO_W]));
         default:
            b_part = op_b[chrt_pkg::MUL_B_W-1:0];
      endcase
   end

   // accumulate stage
   always_comb begin
      term = chrt_pkg::ACC_W'(prod_ff);
      if (uop_ff.part == chrt_pkg::PART_HI) begin
         term = term <<< chrt_pkg::LO_W;
      end
      if (uop_ff.neg) begin
         term = -term;
      end
      case (uop_ff.mode)
         chrt_pkg::ACC_ADD: base = acc_ff;
         chrt_pkg::ACC_ORIGIN: begin
            case (uop_ff.dst)
               chrt_pkg::DST_HY: base = chrt_pkg::ACC_W'(org_ff[1]) <<< chrt_pkg::FRAC_W;
               chrt_pkg::DST_HZ: base = chrt_pkg::ACC_W'(org_ff[2]) <<< chrt_pkg::FRAC_W;
               default:          base = chrt_pkg::ACC_W'(org_ff[0]) <<< chrt_pkg::FRAC_W;
            endcase
         end
         default: base = '0;
      endcase
      acc_in = base + term;
      // arithmetic shift floors toward minus infinity
      flo = acc_in >>> chrt_pkg::FRAC_W;
      if (flo > COORD_MAX) begin
         coord_sat = COORD_MAX[chrt_pkg::COORD_W-1:0];
      end else if (flo < COORD_MIN) begin
         coord_sat = COORD_MIN[chrt_pkg::COORD_W-1:0];
      end else begin
         coord_sat = flo[chrt_pkg::COORD_W-1:0];
      end
   end

   // checks, divider step, distance pick
   always_comb begin
      abs_det = det_ff[chrt_pkg::ACC_W-1] ? -det_ff : det_ff;
      degen   = (det_ff == '0) ||
                ($unsigned(abs_det) < chrt_pkg::ACC_W'(min_det_ff));
      sum_uv  = un_ff + vn_ff;
      bad     = (un_ff < 0) || (det_ff < un_ff) || (vn_ff < 0) ||
                (det_ff < sum_uv) || (tn_ff <= 0);
      div_ge  = rem_ff >= dsh_ff;
      t_q     = sat_ff ? '1 : t_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * b_part;
      uop_ff  <= cmd.uop;
      if (cmd.capture) begin
         e1_ff[0] <= chrt_pkg::DIFF_W'(tri_in.vertex_b_x) - chrt_pkg::DIFF_W'(tri_in.vertex_a_x);
         e1_ff[1] <= chrt_pkg::DIFF_W'(tri_in.vertex_b_y) - chrt_pkg::DIFF_W'(tri_in.vertex_a_y);
         e1_ff[2] <= chrt_pkg::DIFF_W'(tri_in.vertex_b_z) - chrt_pkg::DIFF_W'(tri_in.vertex_a_z);
         e2_ff[0] <= chrt_pkg::DIFF_W'(tri_in.vertex_c_x) - chrt_pkg::DIFF_W'(tri_in.vertex_a_x);
         e2_ff[1] <= chrt_pkg::DIFF_W'(tri_in.vertex_c_y) - chrt_pkg::DIFF_W'(tri_in.vertex_a_y);
         e2_ff[2] <= chrt_pkg::DIFF_W'(tri_in.vertex_c_z) - chrt_pkg::DIFF_W'(tri_in.vertex_a_z);
         s_ff[0]  <= chrt_pkg::DIFF_W'(org_ff[0]) - chrt_pkg::DIFF_W'(tri_in.vertex_a_x);
         s_ff[1]  <= chrt_pkg::DIFF_W'(org_ff[1]) - chrt_pkg::DIFF_W'(tri_in.vertex_a_y);
         s_ff[2]  <= chrt_pkg::DIFF_W'(org_ff[2]) - chrt_pkg::DIFF_W'(tri_in.vertex_a_z);
         mesh_ff  <= tri_in.mesh_number;
         tri_ff   <= tri_in.triangle_number;
         last_ff  <= tri_in.last_triangle;
      end
      if (uop_v_ff) begin
         acc_ff <= acc_in;
         case (uop_ff.dst)
            chrt_pkg::DST_P0:  p_ff[0]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_P1:  p_ff[1]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_P2:  p_ff[2]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_Q0:  q_ff[0]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_Q1:  q_ff[1]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_Q2:  q_ff[2]  <= acc_in[chrt_pkg::WIDE_B_W-1:0];
            chrt_pkg::DST_DET: det_ff   <= acc_in;
            chrt_pkg::DST_UN:  un_ff    <= acc_in;
            chrt_pkg::DST_VN:  vn_ff    <= acc_in;
            chrt_pkg::DST_TN:  tn_ff    <= acc_in;
            chrt_pkg::DST_HX:  hpt_ff[0] <= coord_sat;
            chrt_pkg::DST_HY:  hpt_ff[1] <= coord_sat;
            chrt_pkg::DST_HZ:  hpt_ff[2] <= coord_sat;
            default: ;
         endcase
      end
      if (cmd.adjust) begin
         ok_ff <= !degen;
         // make det positive; flip the numerators with it
         if (det_ff[chrt_pkg::ACC_W-1]) begin
            det_ff <= -det_ff;
            un_ff  <= -un_ff;
            vn_ff  <= -vn_ff;
            tn_ff  <= -tn_ff;
         end
      end
      if (cmd.check) begin
         ok_ff <= ok_ff && !bad;
      end
      if (cmd.div_init) begin
         sat_ff <= (chrt_pkg::REM_W'($unsigned(tn_ff)) << chrt_pkg::FRAC_W) >=
                   (chrt_pkg::REM_W'($unsigned(det_ff)) << chrt_pkg::DIST_W);
         rem_ff <= chrt_pkg::REM_W'($unsigned(tn_ff)) << chrt_pkg::FRAC_W;
         dsh_ff <= chrt_pkg::REM_W'($unsigned(det_ff)) << (chrt_pkg::DIST_W - 1);
         t_ff   <= '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         t_ff   <= {t_ff[chrt_pkg::DIST_W-2:0], div_ge};
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.load_out) begin
         res_ff.hit          <= found_ff;
         res_ff.hit_x        <= found_ff ? hpt_ff[0] : '0;
         res_ff.hit_y        <= found_ff ? hpt_ff[1] : '0;
         res_ff.hit_z        <= found_ff ? hpt_ff[2] : '0;
         res_ff.hit_distance <= found_ff ? best_ff : '0;
         res_ff.hit_mesh     <= found_ff ? best_mesh_ff : '0;
         res_ff.hit_triangle <= found_ff ? best_tri_ff : '0;
      end
   end

   // query state
   always_ff @(posedge clock) begin
      if (reset) begin
         uop_v_ff     <= 1'b0;
         found_ff     <= 1'b0;
         best_ff      <= '1;
         best_mesh_ff <= '0;
         best_tri_ff  <= '0;
      end else begin
         uop_v_ff <= cmd.uop_valid;
         if (cmd.update && ok_ff && (t_q != '0) && (!found_ff || (t_q < best_ff))) begin
            found_ff     <= 1'b1;
            best_ff      <= t_q;
            best_mesh_ff <= mesh_ff;
            best_tri_ff  <= tri_ff;
         end else if (cmd.load_out) begin
            found_ff     <= 1'b0;
            best_ff      <= '1;
            best_mesh_ff <= '0;
            best_tri_ff  <= '0;
         end
      end
   end

   assign stat.last = last_ff;
   assign res       = res_ff;

endmodule

>>> sv/chrt_ctrl.sv
// Controller: sequences the microprogram, checks, divider and result load,
// and owns the request and result handshakes. Uses chrt_pkg and the macro header.
`include "closest_hit_ray_triangle_defines.svh"

module chrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output chrt_pkg::cmd_type  cmd,
   input  chrt_pkg::stat_type stat
);

   chrt_pkg::ctrl_state_type     state_ff, state_in;
   logic [chrt_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [chrt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chrt_pkg::ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.uop      = chrt_pkg::uop_rom(pc_ff);
      unique case (state_ff)
         chrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               pc_in       = '0;
               state_in    = chrt_pkg::ST_MAC;
            end
         end
         chrt_pkg::ST_MAC: begin
            cmd.uop_valid = 1'b1;
            if (pc_ff == chrt_pkg::PC_DOT_LAST) begin
               state_in = chrt_pkg::ST_MAC_DRAIN;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         chrt_pkg::ST_MAC_DRAIN: state_in = chrt_pkg::ST_ADJUST;
         chrt_pkg::ST_ADJUST: begin
            cmd.adjust = 1'b1;
            state_in   = chrt_pkg::ST_CHECK;
         end
         chrt_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = chrt_pkg::ST_DIV_INIT;
         end
         chrt_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = chrt_pkg::CNT_W'(chrt_pkg::DIST_W - 1);
            state_in     = chrt_pkg::ST_DIV;
         end
         chrt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = chrt_pkg::ST_UPDATE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         chrt_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            if (stat.last) begin
               pc_in    = chrt_pkg::PC_HIT_FIRST;
               state_in = chrt_pkg::ST_HIT;
            end else begin
               state_in = chrt_pkg::ST_IDLE;
            end
         end
         chrt_pkg::ST_HIT: begin
            cmd.uop_valid = 1'b1;
            if (pc_ff == chrt_pkg::PC_HIT_LAST) begin
               state_in = chrt_pkg::ST_HIT_DRAIN;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         chrt_pkg::ST_HIT_DRAIN: state_in = chrt_pkg::ST_LOAD;
         chrt_pkg::ST_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = chrt_pkg::ST_IDLE;
            end
         end
         default: state_in = chrt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `CHRT_ASSERT_IMP(a_load_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `CHRT_ASSERT_NXT(a_accept_starts, clock, reset, state_ff == chrt_pkg::ST_IDLE && req_valid, state_ff == chrt_pkg::ST_MAC && pc_ff == '0)
   `CHRT_ASSERT_NXT(a_div_ends, clock, reset, state_ff == chrt_pkg::ST_DIV && cnt_ff == '0, state_ff == chrt_pkg::ST_UPDATE)
   `CHRT_ASSERT_IMP(a_uop_window, clock, reset, cmd.uop_valid, state_ff == chrt_pkg::ST_MAC || state_ff == chrt_pkg::ST_HIT)

endmodule

>>> sv/closest_hit_ray_triangle.sv
// Top level of the closest-hit ray/triangle engine: controller plus datapath.
// Depends on chrt_pkg, the three channel interfaces, chrt_ctrl and chrt_datapath.
//
//   channel   modport  direction  carries
//   req_if    sink     in         one triangle, identifiers, last flag
//   rsp_if    source   out        closest hit of the query
//   csr_if    sink     in         ray origin, direction, det threshold
//
// Each triangle runs the microprogram on the single shared 25x27 multiplier,
// then the checks and the one-bit-per-cycle divider, before the next acceptance.
// A last triangle also computes the hit point; the result then sits in an
// output register, and the next triangle is taken while it waits.
// Reset is synchronous and initialises the ray registers and the query state.
// Register writes are always taken; csr_if.ready stays high.
module closest_hit_ray_triangle (
   input logic       clock,
   input logic       reset,
   chrt_req_if.sink   req_if,
   chrt_rsp_if.source rsp_if,
   chrt_csr_if.sink   csr_if
);

   chrt_pkg::cmd_type  cmd;
   chrt_pkg::stat_type stat;
   chrt_pkg::tri_type  tri_in;
   chrt_pkg::res_type  res;

   assign tri_in.vertex_a_x      = req_if.vertex_a_x;
   assign tri_in.vertex_a_y      = req_if.vertex_a_y;
   assign tri_in.vertex_a_z      = req_if.vertex_a_z;
   assign tri_in.vertex_b_x      = req_if.vertex_b_x;
   assign tri_in.vertex_b_y      = req_if.vertex_b_y;
   assign tri_in.vertex_b_z      = req_if.vertex_b_z;
   assign tri_in.vertex_c_x      = req_if.vertex_c_x;
   assign tri_in.vertex_c_y      = req_if.vertex_c_y;
   assign tri_in.vertex_c_z      = req_if.vertex_c_z;
   assign tri_in.mesh_number     = req_if.mesh_number;
   assign tri_in.triangle_number = req_if.triangle_number;
   assign tri_in.last_triangle   = req_if.last_triangle;

   assign csr_if.ready = 1'b1;

   chrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   chrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .tri_in    (tri_in),
      .csr_we    (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .res       (res)
   );

   assign rsp_if.hit          = res.hit;
   assign rsp_if.hit_x        = res.hit_x;
   assign rsp_if.hit_y        = res.hit_y;
   assign rsp_if.hit_z        = res.hit_z;
   assign rsp_if.hit_distance = res.hit_distance;
   assign rsp_if.hit_mesh     = res.hit_mesh;
   assign rsp_if.hit_triangle = res.hit_triangle;

endmodule
